/* design/iee_pkg.sv */
`default_nettype none
package iee_pkg;

	localparam logic [2:0] OP_OPEN = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DIVZERO   = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_MALFORMED = 2'd3;

	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic ld_char;
		logic digit;
		logic sign;
		logic finish;
		logic push_open;
		logic push_oper;
		logic pop_open;
		logic flag_mal;
		logic fetch;
		logic reduce;
		logic alu_wr;
		logic div_start;
		logic div_wr;
		logic final_chk;
		logic emit;
	} iee_cmd_t;

	typedef struct packed {
		logic [1:0] err;
		logic       last;
		logic       is_digit;
		logic       is_sign;
		logic       is_open;
		logic       is_close;
		logic       is_oper;
		logic       opc_zero;
		logic       top_open;
		logic       prec_break;
		logic       reduce_bad;
		logic       top_div;
		logic       div_busy;
	} iee_sts_t;

	function automatic logic ch_digit(input logic [7:0] ch);
		return (ch >= CH_0) && (ch <= CH_9);
	endfunction

	function automatic logic ch_open(input logic [7:0] ch);
		return ch inside {CH_LPAREN, CH_LBRACK, CH_LBRACE};
	endfunction

	function automatic logic ch_close(input logic [7:0] ch);
		return ch inside {CH_RPAREN, CH_RBRACK, CH_RBRACE};
	endfunction

	function automatic logic ch_oper(input logic [7:0] ch);
		return ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
	endfunction

	function automatic logic [2:0] ch_opcode(input logic [7:0] ch);
		logic [2:0] op;
		case (ch)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			default:  op = OP_OPEN;
		endcase
		return op;
	endfunction

endpackage
`default_nettype wire

/* design/infix_expression_evaluator_unit.sv */
`default_nettype none
// Evaluates an integer infix expression fed one ASCII character per transaction, the final
// character marked by last, and returns one value and status per expression. Operands and
// operators live in two on-chip stacks of STACK_DEPTH entries each, read through registers
// in the cycle after the address is issued. A digit or a sign is decoded in S_CHAR; an
// ignored character or an open bracket then passes S_DISP, and an operator or a close
// bracket S_DISP, S_FETCH and S_DECIDE. Each reduction adds S_EXEC for + - * or a wait in
// S_DIVW on the 32-step restoring divider for /. The last character adds the final reductions
// and the result stays on the output until taken; no new character is accepted meanwhile.
module infix_expression_evaluator_unit import iee_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               char_valid,
	output logic                    char_stall,
	input  wire logic [7:0]         char_in,
	input  wire logic               last,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [31:0]      value,
	output logic [1:0]              status
);

	iee_cmd_t cmd;
	iee_sts_t sts;

	iee_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	iee_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_in),
		.last    (last),
		.cmd     (cmd),
		.sts     (sts),
		.value   (value),
		.status  (status)
	);

endmodule
`default_nettype wire

/* design/iee_ctrl.sv */
`default_nettype none
module iee_ctrl import iee_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     char_valid,
	output logic          char_stall,
	output logic          result_valid,
	input  wire logic     result_stall,
	input  wire iee_sts_t sts,
	output iee_cmd_t      cmd
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_CHAR   = 11'b00000000010,
		S_DISP   = 11'b00000000100,
		S_FIN    = 11'b00000001000,
		S_FIN2   = 11'b00000010000,
		S_FETCH  = 11'b00000100000,
		S_DECIDE = 11'b00001000000,
		S_EXEC   = 11'b00010000000,
		S_DIVW   = 11'b00100000000,
		S_END    = 11'b01000000000,
		S_OUT    = 11'b10000000000
	} state_t;

	typedef enum logic [1:0] {
		M_CLOSE = 2'd0,
		M_OPER  = 2'd1,
		M_FINAL = 2'd2
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   result_valid_q, result_valid_d;
	state_t exit_st;

	assign char_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign exit_st      = sts.last ? S_FIN : S_IDLE;

	always_comb begin
		state_d        = state_q;
		mode_d         = mode_q;
		result_valid_d = result_valid_q;
		cmd            = '0;
		case (state_q)
			S_IDLE: begin
				if (char_valid) begin
					cmd.ld_char = 1'b1;
					state_d     = S_CHAR;
				end
			end
			S_CHAR: begin
				if (sts.err != ST_OK) begin
					state_d = sts.last ? S_END : S_IDLE;
				end else if (sts.is_digit) begin
					cmd.digit = 1'b1;
					state_d   = exit_st;
				end else if (sts.is_sign) begin
					cmd.sign = 1'b1;
					state_d  = exit_st;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.err != ST_OK) begin
					state_d = exit_st;
				end else if (sts.is_open) begin
					cmd.push_open = 1'b1;
					state_d       = exit_st;
				end else if (sts.is_close) begin
					mode_d  = M_CLOSE;
					state_d = S_FETCH;
				end else if (sts.is_oper) begin
					mode_d  = M_OPER;
					state_d = S_FETCH;
				end else begin
					state_d = exit_st;
				end
			end
			S_FIN: begin
				if (sts.err != ST_OK) begin
					state_d = S_END;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_FIN2;
				end
			end
			S_FIN2: begin
				if (sts.err != ST_OK) begin
					state_d = S_END;
				end else begin
					mode_d  = M_FINAL;
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.err != ST_OK) begin
					state_d = exit_st;
				end else if (mode_q == M_CLOSE && sts.opc_zero) begin
					cmd.flag_mal = 1'b1;
					state_d      = exit_st;
				end else if (mode_q == M_CLOSE && sts.top_open) begin
					cmd.pop_open = 1'b1;
					state_d      = exit_st;
				end else if (mode_q == M_OPER &&
						(sts.opc_zero || sts.top_open || sts.prec_break)) begin
					cmd.push_oper = 1'b1;
					state_d       = exit_st;
				end else if (mode_q == M_FINAL && sts.opc_zero) begin
					cmd.final_chk = 1'b1;
					state_d       = S_END;
				end else if (mode_q == M_FINAL && sts.top_open) begin
					cmd.flag_mal = 1'b1;
					state_d      = S_END;
				end else begin
					cmd.reduce = 1'b1;
					if (sts.reduce_bad) begin
						state_d = S_FETCH;
					end else if (sts.top_div) begin
						cmd.div_start = 1'b1;
						state_d       = S_DIVW;
					end else begin
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				cmd.alu_wr = 1'b1;
				state_d    = S_FETCH;
			end
			S_DIVW: begin
				if (!sts.div_busy) begin
					cmd.div_wr = 1'b1;
					state_d    = S_FETCH;
				end
			end
			S_END: begin
				cmd.emit       = 1'b1;
				result_valid_d = 1'b1;
				state_d        = S_OUT;
			end
			S_OUT: begin
				if (!result_stall) begin
					result_valid_d = 1'b0;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= M_CLOSE;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			mode_q         <= mode_d;
			result_valid_q <= result_valid_d;
		end
	end

	a_valid_only_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> state_q == S_OUT)
		else $error("result valid outside output state");

	a_emit_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_valid)
		else $error("emit did not raise result valid");

	a_accept_to_char: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall) |=> state_q == S_CHAR)
		else $error("accepted transaction not decoded");

endmodule
`default_nettype wire

/* design/iee_dp.sv */
`default_nettype none
module iee_dp import iee_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  char_in,
	input  wire logic        last,
	input  wire iee_cmd_t    cmd,
	output iee_sts_t         sts,
	output logic signed [31:0] value,
	output logic [1:0]       status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [31:0] opnd_mem [STACK_DEPTH];
	logic [2:0]  oper_mem [STACK_DEPTH];

	logic [7:0]    char_q;
	logic          last_q;
	logic [31:0]   acc_q;
	logic          active_q, neg_q, sign_ok_q;
	logic [1:0]    err_q;
	logic [CW-1:0] ocnt_q, opc_q;
	logic [31:0]   rd_a_q, rd_b_q, res_q;
	logic [2:0]    top_q;
	logic [31:0]   value_q;
	logic [1:0]    status_q;

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [4:0]  dcnt_q;
	logic        dneg_q, busy_q;

	logic [CW-1:0] ocnt_m1, ocnt_m2, opc_m1;
	logic [2:0]    oper_code;
	logic [31:0]   num_val, alu_res, div_res, opnd_wdata;
	logic          opnd_full, opc_full, opnd_we, oper_we;
	logic [AW-1:0] opnd_waddr;
	logic          top_valid, b_zero, cnt_lt2;
	logic [1:0]    set_code;
	logic          set_en;
	logic [33:0]   trial;

	assign ocnt_m1   = ocnt_q - CW'(1);
	assign ocnt_m2   = ocnt_q - CW'(2);
	assign opc_m1    = opc_q - CW'(1);
	assign oper_code = ch_opcode(char_q);
	assign num_val   = neg_q ? (32'd0 - acc_q) : acc_q;
	assign opnd_full = ocnt_q >= CW'(STACK_DEPTH);
	assign opc_full  = opc_q >= CW'(STACK_DEPTH);
	assign top_valid = (top_q == OP_ADD) || (top_q == OP_SUB) ||
	                   (top_q == OP_MUL) || (top_q == OP_DIV);
	assign b_zero    = (rd_b_q == 32'd0);
	assign cnt_lt2   = ocnt_q < CW'(2);

	always_comb begin
		sts            = '0;
		sts.err        = err_q;
		sts.last       = last_q;
		sts.is_digit   = ch_digit(char_q);
		sts.is_sign    = (char_q == CH_MINUS) && sign_ok_q;
		sts.is_open    = ch_open(char_q);
		sts.is_close   = ch_close(char_q);
		sts.is_oper    = ch_oper(char_q);
		sts.opc_zero   = (opc_q == '0);
		sts.top_open   = (top_q == OP_OPEN);
		sts.prec_break = ((top_q == OP_ADD) || (top_q == OP_SUB)) &&
		                 ((oper_code == OP_MUL) || (oper_code == OP_DIV));
		sts.reduce_bad = cnt_lt2 || !top_valid || ((top_q == OP_DIV) && b_zero);
		sts.top_div    = (top_q == OP_DIV);
		sts.div_busy   = busy_q;
	end

	always_comb begin
		case (top_q)
			OP_ADD:  alu_res = rd_a_q + rd_b_q;
			OP_SUB:  alu_res = rd_a_q - rd_b_q;
			OP_MUL:  alu_res = rd_a_q * rd_b_q;
			default: alu_res = 32'd0;
		endcase
	end

	assign div_res = dneg_q ? (32'd0 - quo_q) : quo_q;
	assign trial   = {1'b0, rem_q, quo_q[31]} - {2'b00, dvs_q};

	always_comb begin
		set_en   = 1'b0;
		set_code = ST_OK;
		if (cmd.finish && active_q && opnd_full) begin
			set_en   = 1'b1;
			set_code = ST_OVERFLOW;
		end else if (cmd.finish && !active_q && neg_q) begin
			set_en   = 1'b1;
			set_code = ST_MALFORMED;
		end else if ((cmd.push_open || cmd.push_oper) && opc_full) begin
			set_en   = 1'b1;
			set_code = ST_OVERFLOW;
		end else if (cmd.flag_mal) begin
			set_en   = 1'b1;
			set_code = ST_MALFORMED;
		end else if (cmd.reduce && (cnt_lt2 || !top_valid)) begin
			set_en   = 1'b1;
			set_code = ST_MALFORMED;
		end else if (cmd.reduce && (top_q == OP_DIV) && b_zero) begin
			set_en   = 1'b1;
			set_code = ST_DIVZERO;
		end else if (cmd.final_chk && (ocnt_q != CW'(1))) begin
			set_en   = 1'b1;
			set_code = ST_MALFORMED;
		end
	end

	assign opnd_we    = (cmd.finish && active_q && !opnd_full) || cmd.alu_wr || cmd.div_wr;
	assign opnd_waddr = cmd.finish ? ocnt_q[AW-1:0] : ocnt_m1[AW-1:0];
	assign opnd_wdata = cmd.finish ? num_val : (cmd.alu_wr ? alu_res : div_res);
	assign oper_we    = (cmd.push_open || cmd.push_oper) && !opc_full;

	always_ff @(posedge clk) begin
		if (opnd_we) begin
			opnd_mem[opnd_waddr] <= opnd_wdata;
		end
		if (oper_we) begin
			oper_mem[opc_q[AW-1:0]] <= cmd.push_open ? OP_OPEN : oper_code;
		end
		if (cmd.fetch) begin
			rd_b_q <= opnd_mem[ocnt_m1[AW-1:0]];
			rd_a_q <= opnd_mem[ocnt_m2[AW-1:0]];
			top_q  <= oper_mem[opc_m1[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_char) begin
			char_q <= char_in;
			last_q <= last;
		end
		if (cmd.final_chk) begin
			res_q <= rd_b_q;
		end
		if (cmd.div_start) begin
			dvs_q  <= rd_b_q[31] ? (32'd0 - rd_b_q) : rd_b_q;
			quo_q  <= rd_a_q[31] ? (32'd0 - rd_a_q) : rd_a_q;
			rem_q  <= 32'd0;
			dneg_q <= rd_a_q[31] ^ rd_b_q[31];
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= 32'd0;
			active_q  <= 1'b0;
			neg_q     <= 1'b0;
			sign_ok_q <= 1'b1;
			err_q     <= ST_OK;
			ocnt_q    <= '0;
			opc_q     <= '0;
			busy_q    <= 1'b0;
			dcnt_q    <= 5'd0;
			value_q   <= 32'd0;
			status_q  <= ST_OK;
		end else begin
			if (cmd.emit) begin
				value_q   <= (err_q == ST_OK) ? res_q : 32'd0;
				status_q  <= err_q;
				acc_q     <= 32'd0;
				active_q  <= 1'b0;
				neg_q     <= 1'b0;
				sign_ok_q <= 1'b1;
				err_q     <= ST_OK;
				ocnt_q    <= '0;
				opc_q     <= '0;
			end else begin
				if (set_en && (err_q == ST_OK)) begin
					err_q <= set_code;
				end
				if (cmd.digit) begin
					acc_q     <= (active_q ? ((acc_q << 3) + (acc_q << 1)) : 32'd0) +
					             {28'd0, char_q[3:0]};
					active_q  <= 1'b1;
					sign_ok_q <= 1'b0;
				end
				if (cmd.sign) begin
					neg_q     <= 1'b1;
					sign_ok_q <= 1'b0;
				end
				if (cmd.finish) begin
					sign_ok_q <= 1'b0;
					active_q  <= 1'b0;
					neg_q     <= 1'b0;
					acc_q     <= 32'd0;
					if (active_q && !opnd_full) begin
						ocnt_q <= ocnt_q + CW'(1);
					end
				end
				if (cmd.push_open) begin
					sign_ok_q <= 1'b1;
				end
				if (oper_we) begin
					opc_q <= opc_q + CW'(1);
				end
				if (cmd.pop_open) begin
					opc_q <= opc_m1;
				end
				if (cmd.reduce && !sts.reduce_bad) begin
					opc_q  <= opc_m1;
					ocnt_q <= ocnt_m1;
				end
			end
			if (cmd.div_start) begin
				busy_q <= 1'b1;
				dcnt_q <= 5'd0;
			end else if (busy_q) begin
				dcnt_q <= dcnt_q + 5'd1;
				busy_q <= (dcnt_q != 5'd31);
			end
		end
	end

	assign value  = value_q;
	assign status = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ocnt_q <= CW'(STACK_DEPTH)) && (opc_q <= CW'(STACK_DEPTH)))
		else $error("stack count beyond depth");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (ocnt_q == '0) && (opc_q == '0) && (err_q == ST_OK))
		else $error("state not cleared after result");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> busy_q && (dcnt_q == 5'd0))
		else $error("divider did not start");

endmodule
`default_nettype wire
